// ===== design/ptfd_pkg.sv =====
package ptfd_pkg;

   // Character codes of the bar code text
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Marker for a group that is not a two-of-five pattern
   localparam logic [3:0] NO_DIGIT = 4'hF;

   // Number of digit fields on the result
   localparam int NUM_DIGIT_OUT = 8;

   // Register index on the configuration port
   localparam logic REG_EXPECTED_SEP = 1'b0;

   // Reset value of the separator count register
   localparam logic [7:0] EXPECTED_SEP_RESET = 8'd7;

   // Class of one held bar character
   typedef enum logic [1:0] {
      CLASS_ZERO  = 2'd0,
      CLASS_ONE   = 2'd1,
      CLASS_OTHER = 2'd2
   } sym_class_type;

   // One frame result
   typedef struct packed {
      logic                           status;
      logic [3:0]                     code_count;
      logic [NUM_DIGIT_OUT-1:0][3:0]  digit;
   } result_type;

   // Map a character to its bar class
   function automatic sym_class_type classify(input logic [7:0] ch);
      sym_class_type cls;
      if (ch == CHAR_ZERO) begin
         cls = CLASS_ZERO;
      end else if (ch == CHAR_ONE) begin
         cls = CLASS_ONE;
      end else begin
         cls = CLASS_OTHER;
      end
      return cls;
   endfunction

   // Two-of-five group to digit
   function automatic logic [3:0] pattern_digit(input logic [4:0] bits);
      logic [3:0] d;
      case (bits)
         5'b11000: d = 4'd0;
         5'b00011: d = 4'd1;
         5'b00101: d = 4'd2;
         5'b00110: d = 4'd3;
         5'b01001: d = 4'd4;
         5'b01010: d = 4'd5;
         5'b01100: d = 4'd6;
         5'b10001: d = 4'd7;
         5'b10010: d = 4'd8;
         5'b10100: d = 4'd9;
         default:  d = NO_DIGIT;
      endcase
      return d;
   endfunction

endpackage

// ===== design/postnet_text_frame_decoder_top.sv =====
// POSTNET text-frame decoder. Feed the bar code text one ASCII character per word on the
// req_ channel, with req_last on the final character; that word yields exactly one result
// word on the rsp_ channel (status 0 = valid frame, code count and up to eight digits), and
// the decoder then starts over for the next string. A character is taken every cycle, unless
// a closing character finds the result register stalled: each one passes an input register
// and a single update stage, and the closing character loads the result register that drives
// rsp_valid. The required number of spaces is written at byte address 0 of the APB port
// (reset value 7); write it only while no string is in progress.
module postnet_text_frame_decoder_top #(
   parameter int MAX_CODES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [3:0]  rsp_code_count,
   output logic [3:0]  rsp_digit0,
   output logic [3:0]  rsp_digit1,
   output logic [3:0]  rsp_digit2,
   output logic [3:0]  rsp_digit3,
   output logic [3:0]  rsp_digit4,
   output logic [3:0]  rsp_digit5,
   output logic [3:0]  rsp_digit6,
   output logic [3:0]  rsp_digit7,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_ch_ff;
   logic                 in_last_ff;
   logic                 req_accept;
   logic                 out_free;
   logic                 core_step;
   logic                 rsp_valid_ff, rsp_valid_in;
   ptfd_pkg::result_type rsp_data_ff;
   ptfd_pkg::result_type core_result;
   logic [7:0]           expected_sep_ff;
   logic                 csr_write;

   // Configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == ptfd_pkg::REG_EXPECTED_SEP) ? {24'd0, expected_sep_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_sep_ff <= ptfd_pkg::EXPECTED_SEP_RESET;
      end else if (csr_write && paddr[2] == ptfd_pkg::REG_EXPECTED_SEP) begin
         expected_sep_ff <= pwdata[7:0];
      end
   end

   // Step the core unless a closing word finds the result register full and stalled
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign core_step  = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall  = in_valid_ff && !core_step;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept ? 1'b1 : (core_step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
   end

   ptfd_frame_core #(
      .MAX_CODES (MAX_CODES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (core_step),
      .ch           (in_ch_ff),
      .last         (in_last_ff),
      .expected_sep (expected_sep_ff),
      .result       (core_result)
   );

   // Result register
   assign rsp_valid_in = (core_step && in_last_ff) ? 1'b1 :
                         (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_step && in_last_ff) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_code_count = rsp_data_ff.code_count;
   assign rsp_digit0     = rsp_data_ff.digit[0];
   assign rsp_digit1     = rsp_data_ff.digit[1];
   assign rsp_digit2     = rsp_data_ff.digit[2];
   assign rsp_digit3     = rsp_data_ff.digit[3];
   assign rsp_digit4     = rsp_data_ff.digit[4];
   assign rsp_digit5     = rsp_data_ff.digit[5];
   assign rsp_digit6     = rsp_data_ff.digit[6];
   assign rsp_digit7     = rsp_data_ff.digit[7];

   // A closing word never overwrites a stalled result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_step && in_last_ff |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // Stall only with a word held in the input register
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // An invalid frame reports no codes
   a_invalid_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_code_count == 4'd0 && rsp_digit0 == 4'd0)
      else $error("invalid frame carries codes");

   // A valid frame never reports more codes than the store holds
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> 32'(rsp_code_count) <= MAX_CODES)
      else $error("code count beyond limit");

endmodule

// ===== design/ptfd_frame_core.sv =====
module ptfd_frame_core #(
   parameter int MAX_CODES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           ch,
   input  logic                 last,
   input  logic [7:0]           expected_sep,
   output ptfd_pkg::result_type result
);

   localparam int CNT_W = $clog2(MAX_CODES + 1);
   localparam int IDX_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

   // Per-string state
   logic                    started_ff;
   logic                    pend_valid_ff;
   ptfd_pkg::sym_class_type pend_class_ff;
   logic [4:0]              group_bits_ff;
   logic [2:0]              group_fill_ff;
   logic [7:0]              space_count_ff;
   logic [CNT_W-1:0]        codes_seen_ff;
   logic                    bad_ff;
   logic [3:0]              digit_ff [MAX_CODES];

   // Values after this character, before the end-of-string clear
   logic                    started_upd;
   logic                    pend_valid_upd;
   ptfd_pkg::sym_class_type pend_class_upd;
   logic [4:0]              group_bits_upd;
   logic [2:0]              group_fill_upd;
   logic [7:0]              space_count_upd;
   logic [CNT_W-1:0]        codes_seen_upd;
   logic                    bad_upd;

   logic                    push;
   logic [4:0]              shifted_bits;
   logic [2:0]              fill_inc;
   logic [3:0]              new_digit;
   logic                    store_we;
   logic [IDX_W-1:0]        store_idx;
   logic                    frame_ok;
   logic [4:0]              codes_wide;

   assign store_idx = codes_seen_ff[IDX_W-1:0];

   // Advance the frame state by one character
   always_comb begin
      started_upd     = started_ff;
      pend_valid_upd  = pend_valid_ff;
      pend_class_upd  = pend_class_ff;
      group_bits_upd  = group_bits_ff;
      group_fill_upd  = group_fill_ff;
      space_count_upd = space_count_ff;
      codes_seen_upd  = codes_seen_ff;
      bad_upd         = bad_ff;
      push            = 1'b0;
      store_we        = 1'b0;
      shifted_bits    = {group_bits_ff[3:0], (pend_class_ff == ptfd_pkg::CLASS_ONE)};
      fill_inc        = group_fill_ff + 3'd1;
      new_digit       = ptfd_pkg::pattern_digit(shifted_bits);

      if (ch == ptfd_pkg::CHAR_SPACE && space_count_ff != 8'hFF) begin
         space_count_upd = space_count_ff + 8'd1;
      end

      if (!started_ff) begin
         started_upd = 1'b1;
         if (ch != ptfd_pkg::CHAR_ONE) begin
            bad_upd = 1'b1;
         end
      end else if (ch != ptfd_pkg::CHAR_SPACE) begin
         push           = pend_valid_ff;
         pend_valid_upd = !last;
         if (!last) begin
            pend_class_upd = ptfd_pkg::classify(ch);
         end
      end

      // Shift the held bar into the group and decode a full group
      if (push) begin
         if (pend_class_ff == ptfd_pkg::CLASS_OTHER) begin
            bad_upd = 1'b1;
         end
         group_bits_upd = shifted_bits;
         group_fill_upd = fill_inc;
         if (fill_inc == 3'd5) begin
            group_bits_upd = '0;
            group_fill_upd = '0;
            if (new_digit == ptfd_pkg::NO_DIGIT) begin
               bad_upd = 1'b1;
            end else if (codes_seen_ff >= CNT_W'(MAX_CODES)) begin
               bad_upd = 1'b1;
            end else begin
               store_we       = 1'b1;
               codes_seen_upd = codes_seen_ff + CNT_W'(1);
            end
         end
      end
   end

   // Judge the frame on the closing character
   assign frame_ok = started_ff && (ch == ptfd_pkg::CHAR_ONE) && !bad_upd &&
                     (group_fill_upd == 3'd0) && (space_count_upd == expected_sep);

   assign codes_wide = 5'(codes_seen_upd);

   assign result.status     = !frame_ok;
   assign result.code_count = !frame_ok ? 4'd0 :
                              (codes_wide > 5'd15) ? 4'hF : codes_wide[3:0];

   // Select each digit, including one decoded on this character
   for (genvar k = 0; k < ptfd_pkg::NUM_DIGIT_OUT; k++) begin : g_digit
      if (k < MAX_CODES) begin : g_used
         logic [3:0] value;
         assign value = (store_we && store_idx == IDX_W'(k)) ? new_digit : digit_ff[k];
         assign result.digit[k] = (frame_ok && codes_seen_upd > CNT_W'(k)) ? value : 4'd0;
      end else begin : g_absent
         assign result.digit[k] = 4'd0;
      end
   end

   // Hold control state; clear it after the closing character
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         pend_valid_ff  <= 1'b0;
         pend_class_ff  <= ptfd_pkg::CLASS_ZERO;
         group_bits_ff  <= '0;
         group_fill_ff  <= '0;
         space_count_ff <= '0;
         codes_seen_ff  <= '0;
         bad_ff         <= 1'b0;
      end else if (step) begin
         if (last) begin
            started_ff     <= 1'b0;
            pend_valid_ff  <= 1'b0;
            pend_class_ff  <= ptfd_pkg::CLASS_ZERO;
            group_bits_ff  <= '0;
            group_fill_ff  <= '0;
            space_count_ff <= '0;
            codes_seen_ff  <= '0;
            bad_ff         <= 1'b0;
         end else begin
            started_ff     <= started_upd;
            pend_valid_ff  <= pend_valid_upd;
            pend_class_ff  <= pend_class_upd;
            group_bits_ff  <= group_bits_upd;
            group_fill_ff  <= group_fill_upd;
            space_count_ff <= space_count_upd;
            codes_seen_ff  <= codes_seen_upd;
            bad_ff         <= bad_upd;
         end
      end
   end

   // Write a decoded digit into the store
   always_ff @(posedge clock) begin
      if (step && store_we) begin
         digit_ff[store_idx] <= new_digit;
      end
   end

endmodule
